// ----- hdl/mna_pkg.sv -----
// Shared types and constants for the MNA matrix stamper.
// Holds the stamp item layout, the micro-operation passed from front to back
// and the code constants. Depends on nothing.
`timescale 1ns / 1ps

package mna_pkg;

  // Default sizes of the matrix store.
  localparam int DEF_MAX_NODES    = 16;
  localparam int DEF_MAX_BRANCHES = 16;

  // Depth of the micro-operation queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Item action codes.
  localparam logic ACTION_STAMP = 1'b0;
  localparam logic ACTION_READ  = 1'b1;

  // Element kinds.
  localparam logic [1:0] KIND_RESISTOR  = 2'd0;
  localparam logic [1:0] KIND_CAPACITOR = 2'd1;
  localparam logic [1:0] KIND_INDUCTOR  = 2'd2;
  localparam logic [1:0] KIND_VSOURCE   = 2'd3;

  // Configuration register indexes.
  localparam logic REG_NODE_COUNT   = 1'b0;
  localparam logic REG_BRANCH_COUNT = 1'b1;

  // One accepted input beat, unpacked.
  typedef struct packed {
    logic               action;
    logic [1:0]         element_kind;
    logic [4:0]         source_node;
    logic [4:0]         dest_node;
    logic [3:0]         branch_slot;
    logic signed [31:0] element_value;
    logic [4:0]         read_row;
    logic [4:0]         read_col;
  } stamp_item_t;

  // Kinds of single-entry memory operations.
  typedef enum logic [2:0] {
    UOP_ADD,   // saturating add of value to the entry
    UOP_SET,   // write plus one
    UOP_BSUB,  // subtract one unless the entry is already minus one
    UOP_COPY,  // write the value produced by the previous write
    UOP_READ   // return the entry as a result beat
  } uop_kind_t;

  // One memory operation; row and column are already matrix coordinates.
  typedef struct packed {
    uop_kind_t          kind;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
    logic               bad;
  } uop_t;

endpackage

// ----- hdl/mna_front.sv -----
// Front end of the MNA matrix stamper: accepts item beats and expands each
// into a short list of memory operations pushed into the queue.
// Depends on mna_pkg.
`timescale 1ns / 1ps

module mna_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mna_pkg::stamp_item_t item,
  input  logic [4:0]         node_count,
  input  logic [4:0]         branch_count,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output mna_pkg::uop_t      q_op
);
  import mna_pkg::*;

  // Operation slots of a conductance stamp.
  localparam logic [2:0] G_SS = 3'd0;
  localparam logic [2:0] G_DD = 3'd1;
  localparam logic [2:0] G_SD = 3'd2;
  localparam logic [2:0] G_DS = 3'd3;
  // Operation slots of a source or inductor stamp.
  localparam logic [2:0] V_SET   = 3'd0;
  localparam logic [2:0] V_SCOPY = 3'd1;
  localparam logic [2:0] V_SUB   = 3'd2;
  localparam logic [2:0] V_DCOPY = 3'd3;
  localparam logic [2:0] V_IND   = 3'd4;

  logic        busy;
  logic [2:0]  slot;
  stamp_item_t cur;

  logic               s_ok, d_ok, k_ok;
  logic [5:0]         s_idx, d_idx, b_idx, lim;
  logic signed [31:0] neg_v;
  logic               en;
  logic [2:0]         last_slot;
  logic               advance, done_now;

  // Node and branch checks against the current configuration.
  always_comb begin
    s_ok  = (cur.source_node != 5'd0) && (cur.source_node <= node_count);
    d_ok  = (cur.dest_node != 5'd0) && (cur.dest_node <= node_count);
    k_ok  = ({1'b0, cur.branch_slot} < branch_count);
    s_idx = {1'b0, cur.source_node} - 6'd1;
    d_idx = {1'b0, cur.dest_node} - 6'd1;
    b_idx = {1'b0, node_count} + {2'b00, cur.branch_slot};
    lim   = {1'b0, node_count} + {1'b0, branch_count};
    // Negating the most negative value saturates to the largest one.
    if (cur.element_value == 32'sh8000_0000) begin
      neg_v = 32'sh7fff_ffff;
    end else begin
      neg_v = -cur.element_value;
    end
  end

  // Build the operation for the current slot.
  always_comb begin
    q_op.kind  = UOP_READ;
    q_op.row   = 6'd0;
    q_op.col   = 6'd0;
    q_op.value = cur.element_value;
    q_op.bad   = 1'b0;
    en         = 1'b0;
    last_slot  = 3'd0;
    if (cur.action == ACTION_READ) begin
      q_op.row = {1'b0, cur.read_row};
      q_op.col = {1'b0, cur.read_col};
      q_op.bad = ({1'b0, cur.read_row} >= lim) || ({1'b0, cur.read_col} >= lim);
      en       = 1'b1;
    end else if (cur.element_kind == KIND_RESISTOR || cur.element_kind == KIND_CAPACITOR) begin
      last_slot = G_DS;
      q_op.kind = UOP_ADD;
      unique case (slot)
        G_SS: begin
          q_op.row = s_idx;
          q_op.col = s_idx;
          en       = s_ok;
        end
        G_DD: begin
          q_op.row = d_idx;
          q_op.col = d_idx;
          en       = d_ok;
        end
        G_SD: begin
          q_op.row   = s_idx;
          q_op.col   = d_idx;
          q_op.value = neg_v;
          en         = s_ok && d_ok;
        end
        G_DS: begin
          q_op.row   = d_idx;
          q_op.col   = s_idx;
          q_op.value = neg_v;
          en         = s_ok && d_ok;
        end
        default: begin
          en = 1'b0;
        end
      endcase
    end else begin
      last_slot = V_IND;
      unique case (slot)
        V_SET: begin
          q_op.kind = UOP_SET;
          q_op.row  = s_idx;
          q_op.col  = b_idx;
          en        = s_ok && k_ok;
        end
        V_SCOPY: begin
          q_op.kind = UOP_COPY;
          q_op.row  = b_idx;
          q_op.col  = s_idx;
          en        = s_ok && k_ok;
        end
        V_SUB: begin
          q_op.kind = UOP_BSUB;
          q_op.row  = d_idx;
          q_op.col  = b_idx;
          en        = d_ok && k_ok;
        end
        V_DCOPY: begin
          q_op.kind = UOP_COPY;
          q_op.row  = b_idx;
          q_op.col  = d_idx;
          en        = d_ok && k_ok;
        end
        V_IND: begin
          q_op.kind  = UOP_ADD;
          q_op.row   = b_idx;
          q_op.col   = b_idx;
          q_op.value = neg_v;
          en         = k_ok && (cur.element_kind == KIND_INDUCTOR);
        end
        default: begin
          en = 1'b0;
        end
      endcase
    end
  end

  // Slot stepping; a skipped slot is passed without a push, a pushed one waits for room.
  always_comb begin
    q_push   = busy && en && !q_full;
    advance  = busy && (!en || !q_full);
    done_now = advance && (slot == last_slot);
    s_tready = !clearing && (!busy || done_now);
  end

  // Item register and slot counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= 3'd0;
    end else if (s_tvalid && s_tready) begin
      busy <= 1'b1;
      slot <= 3'd0;
    end else if (done_now) begin
      busy <= 1'b0;
    end else if (advance) begin
      slot <= slot + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cur <= item;
    end
  end

endmodule

// ----- hdl/mna_queue.sv -----
// Short queue of memory operations between front and back of the stamper.
// Register based, one push and one pop per cycle. Depends on mna_pkg.
`timescale 1ns / 1ps

module mna_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mna_pkg::uop_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output mna_pkg::uop_t head
);
  import mna_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  uop_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  always_comb begin
    full  = (count == (PW+1)'(QUEUE_DEPTH));
    valid = (count != '0);
    head  = slots[rptr];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_op;
    end
  end

endmodule

// ----- hdl/mna_back.sv -----
// Back end of the MNA matrix stamper: holds the matrix memory and executes
// queued operations in a two-stage read-modify-write pipe with forwarding.
// Depends on mna_pkg.
`timescale 1ns / 1ps

module mna_back #(
  parameter int MAX_NODES    = mna_pkg::DEF_MAX_NODES,
  parameter int MAX_BRANCHES = mna_pkg::DEF_MAX_BRANCHES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  mna_pkg::uop_t      q_head,
  output logic               q_pop,
  output logic               clearing,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic signed [31:0] entry_value,
  output logic               bad_index
);
  import mna_pkg::*;

  localparam int DIM   = MAX_NODES + MAX_BRANCHES;
  localparam int RW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW    = 2 * RW;
  localparam int DEPTH = 1 << AW;
  localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [31:0] Q_NEG_ONE = -32'sh0001_0000;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic [AW-1:0]      clr_addr;

  uop_t               s2_op;
  logic               s2_valid;
  logic               fwd_hit;
  logic signed [31:0] fwd_data;
  logic signed [31:0] last_val;

  logic               adv, re, we2, we;
  logic [AW-1:0]      raddr, s2_addr, waddr;
  logic signed [31:0] operand, s2_wdata, wdata;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] sum;
    sum = {a[31], a} + {b[31], b};
    if (sum[32] != sum[31]) begin
      return sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return sum[31:0];
  endfunction

  // Stage one pops and issues the read; stage two computes and writes.
  always_comb begin
    adv     = !(s2_valid && s2_op.kind == UOP_READ && m_tvalid && !m_tready);
    q_pop   = adv && q_valid && !clearing;
    re      = q_pop;
    raddr   = {RW'(q_head.row), RW'(q_head.col)};
    s2_addr = {RW'(s2_op.row), RW'(s2_op.col)};
    operand = fwd_hit ? fwd_data : rdata;
    unique case (s2_op.kind)
      UOP_ADD:  s2_wdata = sat_add(operand, s2_op.value);
      UOP_SET:  s2_wdata = Q_ONE;
      UOP_BSUB: s2_wdata = (operand == Q_NEG_ONE) ? operand : sat_add(operand, Q_NEG_ONE);
      UOP_COPY: s2_wdata = last_val;
      UOP_READ: s2_wdata = operand;
      default:  s2_wdata = operand;
    endcase
    we2   = s2_valid && (s2_op.kind != UOP_READ);
    we    = clearing || we2;
    waddr = clearing ? clr_addr : s2_addr;
    wdata = clearing ? 32'sd0 : s2_wdata;
  end

  // Matrix memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Pipe registers and the one-deep forwarding path.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (adv) begin
      s2_valid <= q_pop;
      fwd_hit  <= q_pop && we2 && (raddr == s2_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op    <= q_head;
      fwd_data <= s2_wdata;
    end
    if (we2) begin
      last_val <= s2_wdata;
    end
  end

  // Result register; a new read result takes the place of one being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && s2_valid && s2_op.kind == UOP_READ) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_op.kind == UOP_READ) begin
      entry_value <= s2_op.bad ? 32'sd0 : operand;
      bad_index   <= s2_op.bad;
    end
  end

endmodule

// ----- hdl/mna_matrix_stamper.sv -----
// MNA matrix stamper top level: stream ports, APB configuration registers,
// front end, operation queue and back end. Depends on mna_pkg and submodules.
// A read beat passes the item register, the queue and the back end pipe before
// its result is registered. Reads go in one per cycle while the queue has room;
// a stamp steps through four or five operation slots before the next beat; one
// matrix write per cycle. Reset clears all 2**(2*clog2(MAX_NODES+MAX_BRANCHES))
// entries (1024 by default) in a sweep, during which no item beat is accepted.
`timescale 1ns / 1ps

module mna_matrix_stamper #(
  parameter int MAX_NODES    = mna_pkg::DEF_MAX_NODES,
  parameter int MAX_BRANCHES = mna_pkg::DEF_MAX_BRANCHES
) (
  input  logic        clk,
  input  logic        rst,
  // Item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // source_node[4:0], dest_node[9:5], branch_slot[13:10],
  // element_value[45:14], read_row[50:46], read_col[55:51]
  input  logic [55:0] s_tdata,
  // action[0], element_kind[2:1]
  input  logic [2:0]  s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // entry_value[31:0]
  output logic [31:0] m_tdata,
  // bad_index[0]
  output logic [0:0]  m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mna_pkg::*;

  localparam logic [4:0] NODE_RESET = 5'((MAX_NODES < 16) ? MAX_NODES : 16);

  logic [4:0]         node_count, branch_count;
  stamp_item_t        item;
  logic               clearing;
  logic               q_full, q_push, q_valid, q_pop;
  uop_t               q_op, q_head;
  logic signed [31:0] entry_value;
  logic               bad_index;
  logic               cfg_wr;
  logic [4:0]         wval;

  // Configuration registers; values beyond the store size are clamped.
  always_comb begin
    pready = 1'b1;
    cfg_wr = psel && penable && pwrite && pready;
    wval   = pwdata[4:0];
    unique case (paddr[2])
      REG_NODE_COUNT:   prdata = {27'd0, node_count};
      REG_BRANCH_COUNT: prdata = {27'd0, branch_count};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= NODE_RESET;
      branch_count <= 5'd0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NODE_COUNT: begin
          node_count <= (int'(wval) > MAX_NODES) ? 5'(MAX_NODES) : wval;
        end
        REG_BRANCH_COUNT: begin
          branch_count <= (int'(wval) > MAX_BRANCHES) ? 5'(MAX_BRANCHES) : wval;
        end
        default: begin
          node_count <= node_count;
        end
      endcase
    end
  end

  // Unpack the input beat.
  always_comb begin
    item.action        = s_tuser[0];
    item.element_kind  = s_tuser[2:1];
    item.source_node   = s_tdata[4:0];
    item.dest_node     = s_tdata[9:5];
    item.branch_slot   = s_tdata[13:10];
    item.element_value = s_tdata[45:14];
    item.read_row      = s_tdata[50:46];
    item.read_col      = s_tdata[55:51];
    m_tdata            = entry_value;
    m_tuser            = bad_index;
  end

  mna_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .item         (item),
    .node_count   (node_count),
    .branch_count (branch_count),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_op         (q_op)
  );

  mna_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_op),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head)
  );

  mna_back #(
    .MAX_NODES    (MAX_NODES),
    .MAX_BRANCHES (MAX_BRANCHES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .entry_value (entry_value),
    .bad_index   (bad_index)
  );

endmodule

// ----- tb/sv/mna_matrix_stamper_tb.sv -----
// Self-checking testbench for the MNA matrix stamper: streams stamp and read
// beats, predicts every read result in a scoreboard class and checks them.
// Depends on mna_pkg and the mna_matrix_stamper top level.
`timescale 1ns / 1ps

module mna_matrix_stamper_tb;
  import mna_pkg::*;

  localparam int MAT_DIM = DEF_MAX_NODES + DEF_MAX_BRANCHES;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  // Cycles to let the back end finish queued stamps that give no result.
  localparam int SETTLE_CYCLES = 40;
  // Cycles with no accepted beat before the run is declared hung; covers the
  // clearing sweep after reset and the long receiver hold-off.
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 258;
  localparam int NUM_PHASES = 6;

  // Matrix predictor and store of expected read results.
  class mna_scoreboard;
    typedef struct {
      logic signed [31:0] value;
      logic               bad;
    } read_result_t;

    logic signed [31:0] entries [0:MAT_DIM-1][0:MAT_DIM-1];
    int unsigned node_limit;
    int unsigned branch_limit;
    read_result_t pending_reads [$];
    int errors;
    int stamps;
    int reads;
    int checked;

    function new();
      foreach (entries[r, c]) entries[r][c] = '0;
      node_limit = DEF_MAX_NODES;
      branch_limit = 0;
      errors = 0;
      stamps = 0;
      reads = 0;
      checked = 0;
    endfunction

    function logic signed [31:0] sat32(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    function void set_register(logic idx, logic [31:0] val);
      int unsigned v;
      v = {27'd0, val[4:0]};
      if (idx == REG_NODE_COUNT)
        node_limit = (v > DEF_MAX_NODES) ? DEF_MAX_NODES : v;
      else
        branch_limit = (v > DEF_MAX_BRANCHES) ? DEF_MAX_BRANCHES : v;
    endfunction

    // Conductance update in G; ground and out-of-range nodes are skipped.
    function void add_conductance(int unsigned a, int unsigned b, logic signed [31:0] v);
      if (a == 0 || b == 0 || a > node_limit || b > node_limit) return;
      entries[a-1][b-1] = sat32(longint'(entries[a-1][b-1]) + longint'(v));
    endfunction

    // Incidence write in B, mirrored into C.
    function void write_incidence(int unsigned node, int unsigned k, bit set_one);
      logic signed [31:0] cur;
      if (node == 0 || node > node_limit || k >= branch_limit) return;
      cur = entries[node-1][node_limit+k];
      if (set_one)
        cur = Q_ONE;
      else if (cur != -Q_ONE)
        cur = sat32(longint'(cur) - longint'(Q_ONE));
      entries[node-1][node_limit+k] = cur;
      entries[node_limit+k][node-1] = cur;
    endfunction

    // Called for every accepted input beat.
    function void apply_item(stamp_item_t it);
      logic signed [31:0] v;
      logic signed [31:0] nv;
      read_result_t exp;
      int unsigned lim;
      int unsigned k;
      int unsigned s;
      int unsigned d;
      v = it.element_value;
      nv = sat32(-longint'(v));
      k = 32'(it.branch_slot);
      s = 32'(it.source_node);
      d = 32'(it.dest_node);
      if (it.action == ACTION_READ) begin
        reads++;
        lim = node_limit + branch_limit;
        if (it.read_row >= lim || it.read_col >= lim) begin
          exp.value = '0;
          exp.bad = 1'b1;
        end else begin
          exp.value = entries[it.read_row][it.read_col];
          exp.bad = 1'b0;
        end
        pending_reads.push_back(exp);
      end else begin
        stamps++;
        if (it.element_kind == KIND_RESISTOR || it.element_kind == KIND_CAPACITOR) begin
          add_conductance(s, s, v);
          add_conductance(d, d, v);
          add_conductance(s, d, nv);
          add_conductance(d, s, nv);
        end else begin
          write_incidence(s, k, 1'b1);
          write_incidence(d, k, 1'b0);
          if (it.element_kind == KIND_INDUCTOR && k < branch_limit)
            entries[node_limit+k][node_limit+k] =
              sat32(longint'(entries[node_limit+k][node_limit+k]) + longint'(nv));
        end
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    // Called for every accepted result beat.
    task check_result(logic [31:0] got_value, logic got_bad);
      read_result_t exp;
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("result beat %h/%b with no read waiting",
                                  got_value, got_bad));
      end else begin
        exp = pending_reads.pop_front();
        if (got_value !== exp.value)
          report_mismatch($sformatf("result %0d: entry_value %h, expected %h",
                                    checked, got_value, exp.value));
        if (got_bad !== exp.bad)
          report_mismatch($sformatf("result %0d: bad_index %b, expected %b",
                                    checked, got_bad, exp.bad));
      end
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mna_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_request;
  int hold_left;
  int idle_cycles;
  int settings_used;

  mna_matrix_stamper DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_off_request > 0) begin
      hold_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1)
      sb.check_result(m_tdata, m_tuser[0]);
  end

  // Watchdog on cycles in which no beat or register write is accepted.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
        (psel && penable && pwrite && pready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one beat, with random idle cycles first; returns after a falling edge.
  task automatic send_item(input stamp_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {it.read_col, it.read_row, it.element_value, it.branch_slot,
               it.dest_node, it.source_node};
    s_tuser = {it.element_kind, it.action};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.apply_item(it);
    @(negedge clk);
  endtask

  task automatic send_stamp(input logic [1:0] kind, input int s, input int d,
                            input int k, input logic signed [31:0] v);
    stamp_item_t it;
    it.action = ACTION_STAMP;
    it.element_kind = kind;
    it.source_node = 5'(s);
    it.dest_node = 5'(d);
    it.branch_slot = 4'(k);
    it.element_value = v;
    it.read_row = 5'($urandom);
    it.read_col = 5'($urandom);
    send_item(it);
  endtask

  task automatic send_read(input int r, input int c);
    stamp_item_t it;
    it.action = ACTION_READ;
    it.element_kind = 2'($urandom);
    it.source_node = 5'($urandom);
    it.dest_node = 5'($urandom);
    it.branch_slot = 4'($urandom);
    it.element_value = $urandom;
    it.read_row = 5'(r);
    it.read_col = 5'(c);
    send_item(it);
  endtask

  // APB write with setup and access phases; returns after a falling edge.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Stop sending until all reads have returned, then let queued stamps drain.
  task automatic wait_for_results(input int extra_cycles);
    s_tvalid = 1'b0;
    while (sb.pending_reads.size() != 0) @(negedge clk);
    repeat (extra_cycles) @(negedge clk);
  endtask

  task automatic apply_setting(input int nodes, input int branches);
    wait_for_results(SETTLE_CYCLES);
    write_reg(REG_NODE_COUNT, nodes);
    write_reg(REG_BRANCH_COUNT, branches);
    settings_used++;
  endtask

  // Mostly in-range stamps and reads; some out-of-range nodes, branches and indexes.
  function automatic stamp_item_t random_item(int unsigned n, int unsigned m);
    stamp_item_t it;
    int unsigned pick;
    it.action = ($urandom_range(99) < 35) ? ACTION_READ : ACTION_STAMP;
    it.element_kind = 2'($urandom_range(3));
    it.source_node = 5'(($urandom_range(99) < 85) ? $urandom_range(n) : $urandom_range(16));
    it.dest_node = 5'(($urandom_range(99) < 85) ? $urandom_range(n) : $urandom_range(16));
    it.branch_slot = 4'((m > 0 && $urandom_range(99) < 85) ? $urandom_range(m - 1)
                                                           : $urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.element_value = $signed($urandom_range(32'h4_0000)) - 32'sh2_0000;
    end else if (pick < 60) begin
      case ($urandom_range(5))
        0: it.element_value = 32'sh7FFF_FFFF;
        1: it.element_value = 32'sh8000_0000;
        2: it.element_value = 32'sh0000_0000;
        3: it.element_value = 32'shFFFF_FFFF;
        4: it.element_value = Q_ONE;
        default: it.element_value = -Q_ONE;
      endcase
    end else begin
      it.element_value = $urandom;
    end
    it.read_row = 5'(($urandom_range(99) < 80) ? $urandom_range(n + m - 1)
                                               : $urandom_range(31));
    it.read_col = 5'(($urandom_range(99) < 80) ? $urandom_range(n + m - 1)
                                               : $urandom_range(31));
    return it;
  endfunction

  int phase_nodes [NUM_PHASES] = '{16, 1, 8, 1, 31, 11};
  int phase_branches [NUM_PHASES] = '{16, 0, 5, 16, 31, 3};
  int phase_send_idle [NUM_PHASES] = '{0, 49, 0, 16, 0, 0};
  int phase_recv_stall [NUM_PHASES] = '{0, 0, 49, 16, 0, 49};

  initial begin
    stamp_item_t it;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_request = 0;
    hold_left = 0;
    idle_cycles = 0;
    settings_used = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part on the full-size matrix: saturation, ground, sources.
    apply_setting(16, 16);
    send_stamp(KIND_RESISTOR, 1, 2, 0, Q_ONE);
    send_stamp(KIND_CAPACITOR, 16, 0, 0, 32'sh7FFF_FFFF);
    send_stamp(KIND_CAPACITOR, 16, 0, 0, 32'sh7FFF_FFFF);
    send_stamp(KIND_RESISTOR, 3, 4, 0, 32'sh8000_0000);
    send_stamp(KIND_RESISTOR, 3, 4, 0, 32'sh8000_0000);
    send_stamp(KIND_VSOURCE, 1, 2, 0, 0);
    send_stamp(KIND_VSOURCE, 5, 2, 0, 0);
    send_stamp(KIND_INDUCTOR, 0, 0, 15, 32'sh0002_0000);
    send_stamp(KIND_INDUCTOR, 6, 7, 3, 32'sh8000_0000);
    send_stamp(KIND_VSOURCE, 16, 16, 15, 32'shFFFF_FFFF);
    send_read(0, 0);
    send_read(0, 1);
    send_read(15, 15);
    send_read(2, 3);
    send_read(1, 16);
    send_read(16, 1);
    send_read(31, 31);
    send_read(19, 19);
    send_read(0, 31);

    // Directed part on a small matrix: nodes and branches out of range, bad reads.
    apply_setting(4, 2);
    send_stamp(KIND_RESISTOR, 5, 1, 0, 32'sh0003_0000);
    send_stamp(KIND_VSOURCE, 1, 3, 2, 0);
    send_read(0, 0);
    send_read(6, 0);
    send_read(0, 6);
    send_read(5, 5);
    send_read(31, 31);

    // Random phases over several register settings and idling modes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(phase_nodes[p], phase_branches[p]);
      send_idle_pct = phase_send_idle[p];
      recv_stall_pct = phase_recv_stall[p];
      if (p == 0) hold_off_request = HOLD_OFF_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        it = random_item(sb.node_limit, sb.branch_limit);
        // Keep reads coming while the receiver holds off, so the block backs up.
        if (p == 0 && i < 48) it.action = ACTION_READ;
        if (p == 3 && i == PHASE_ITEMS / 2) wait_for_results(0);
        send_item(it);
      end
    end

    wait_for_results(SETTLE_CYCLES);
    $display("Run covered %0d stamp beats and %0d read beats over %0d register settings.",
             sb.stamps, sb.reads, settings_used);
    $display("Checked %0d result beats under mixed sender and receiver idling, %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_reads.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mna_pkg.sv
hdl/mna_front.sv
hdl/mna_queue.sv
hdl/mna_back.sv
hdl/mna_matrix_stamper.sv
tb/sv/mna_matrix_stamper_tb.sv
